FILE: hw/rtl/pdtt_pkg.sv
// ---------------------------------------------------------------------------
// pdtt_pkg
// Shared types and constants of the panel duration timeline table.
// ---------------------------------------------------------------------------
package pdtt_pkg;

    localparam int CMD_W   = 3;
    localparam int PANEL_W = 9;
    localparam int DUR_W   = 16;
    localparam int POS_W   = 24;

    localparam logic [CMD_W-1:0] CMD_SET_DUR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET_DUR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LENGTH    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SAME      = 3'd5;

    localparam logic [POS_W-1:0] VALUE_MAX = 24'hFFFFFF;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_WALK = 5'b00100,
        ST_GETD = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

endpackage

FILE: hw/rtl/pdtt_table.sv
// ---------------------------------------------------------------------------
// pdtt_table
// Duration storage: one write port, one registered read port, and a
// clearing pass after reset that zeroes one entry per cycle.
// ---------------------------------------------------------------------------
module pdtt_table #(
    parameter int MAX_PANELS    = 256,
    parameter int DURATION_BITS = 16,
    parameter int IW            = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [IW-1:0]            i_waddr,
    input  logic [DURATION_BITS-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [IW-1:0]            i_raddr,
    output logic [DURATION_BITS-1:0] o_rdata,
    output logic                     o_clearing
);

    logic [DURATION_BITS-1:0] r_mem [MAX_PANELS];
    logic [DURATION_BITS-1:0] r_rdata;
    logic                     r_clearing;
    logic [IW-1:0]            r_clr_idx;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic [DURATION_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == IW'(MAX_PANELS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_comb begin
        wr_en   = r_clearing | i_we;
        wr_addr = r_clearing ? r_clr_idx : i_waddr;
        wr_data = r_clearing ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

FILE: hw/rtl/panel_duration_timeline_table.sv
// ---------------------------------------------------------------------------
// panel_duration_timeline_table
// Per-panel frame duration table with set/get and frame-position queries.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command transaction:
//   set or get a duration, find the panel holding a frame position, give a
//   panel's first frame, give the total length, or compare two positions.
//   Every input transaction yields exactly one output transaction on
//   o_out_valid / i_out_ready.
//   panel_count is written through i_cfg_we / i_cfg_wdata; write it only while idle (not enforced).
// Execution:
//   set: execute, then output; get: execute, table read, then output.
//   find, start, length, same: execute, walk, then output; the walk covers N
//   entries, where N is at most min(panel_count, MAX_PANELS);
//   a single adder and two comparators step through the table one entry per
//   cycle via its registered read port. One command is in flight at a time.
// Reset:
//   i_rst_n is synchronous, active low. After reset a clearing pass zeroes
//   the table with o_in_ready low; config writes are still taken during
//   the pass.
// Stall:
//   the result sits in an output register and the next command is taken
//   meanwhile; its result then waits in the final state, and no further
//   command is taken until the output register drains.
// ---------------------------------------------------------------------------
module panel_duration_timeline_table
    import pdtt_pkg::*;
#(
    parameter int MAX_PANELS    = 256,
    parameter int DURATION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PANEL_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [PANEL_W-1:0] i_panel,
    input  logic [DUR_W-1:0]   i_duration,
    input  logic [POS_W-1:0]   i_pos_a,
    input  logic [POS_W-1:0]   i_pos_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic [PANEL_W-1:0] o_panel_found,
    output logic [POS_W-1:0]   o_value,
    output logic               o_same_panel
);

    localparam int IW    = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
    localparam int CW    = $clog2(MAX_PANELS + 1);
    localparam int SUM_W = DURATION_BITS + CW;
    localparam int PW    = (CW > PANEL_W) ? CW : PANEL_W;
    localparam int XW    = (SUM_W + 1 > POS_W + 1) ? SUM_W + 1 : POS_W + 1;

    t_state r_state, n_state;

    logic [PANEL_W-1:0] r_panel_count;

    logic [CMD_W-1:0]   r_cmd;
    logic [PANEL_W-1:0] r_panel;
    logic [DUR_W-1:0]   r_duration;
    logic [POS_W-1:0]   r_pos_a;
    logic [POS_W-1:0]   r_pos_b;

    logic [CW-1:0]      r_ridx, n_ridx;
    logic [CW-1:0]      r_lim, n_lim;
    logic [CW-1:0]      r_aidx, n_aidx;
    logic               r_dv, n_dv;
    logic [SUM_W-1:0]   r_run, n_run;

    logic               r_res_status, n_res_status;
    logic [PANEL_W-1:0] r_res_found, n_res_found;
    logic [POS_W-1:0]   r_res_value, n_res_value;
    logic               r_res_same, n_res_same;

    logic               r_out_valid;
    logic               r_out_status;
    logic [PANEL_W-1:0] r_out_found;
    logic [POS_W-1:0]   r_out_value;
    logic               r_out_same;

    // table port
    logic                     tbl_we;
    logic [IW-1:0]            tbl_waddr;
    logic [DURATION_BITS-1:0] tbl_wdata;
    logic                     tbl_re;
    logic [IW-1:0]            tbl_raddr;
    logic [DURATION_BITS-1:0] tbl_rdata;
    logic                     tbl_clearing;

    logic [PW-1:0]      cnt_pw;
    logic [PW-1:0]      panel_pw;
    logic [PW-1:0]      panel_m1;
    logic               panel_ok;
    logic [SUM_W-1:0]   run_sum;
    logic               hit_a;
    logic               hit_b;
    logic               walk_issue;
    logic               walk_stop;
    logic [XW-1:0]      tot_x;
    logic [POS_W-1:0]   tot_sat;
    logic               in_fire;
    logic               out_load;

    pdtt_table #(
        .MAX_PANELS    (MAX_PANELS),
        .DURATION_BITS (DURATION_BITS),
        .IW            (IW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (tbl_we),
        .i_waddr    (tbl_waddr),
        .i_wdata    (tbl_wdata),
        .i_re       (tbl_re),
        .i_raddr    (tbl_raddr),
        .o_rdata    (tbl_rdata),
        .o_clearing (tbl_clearing)
    );

    assign o_in_ready = (r_state == ST_IDLE) && !tbl_clearing;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // used panel count, limited to the table depth
    always_comb begin
        if (PW'(r_panel_count) > PW'(MAX_PANELS)) begin
            cnt_pw = PW'(MAX_PANELS);
        end else begin
            cnt_pw = PW'(r_panel_count);
        end
        panel_pw = PW'(r_panel);
        panel_m1 = panel_pw - 1'b1;
        panel_ok = (panel_pw != '0) && (panel_pw <= cnt_pw);
    end

    // shared accumulate and compare step of the walk
    always_comb begin
        run_sum    = r_run + SUM_W'(tbl_rdata);
        hit_a      = XW'(run_sum) >= XW'(r_pos_a);
        hit_b      = XW'(run_sum) >= XW'(r_pos_b);
        walk_issue = (r_ridx != r_lim);
        walk_stop  = 1'b0;
        if (r_dv) begin
            if (r_cmd == CMD_FIND) begin
                walk_stop = hit_a;
            end else if (r_cmd == CMD_SAME) begin
                walk_stop = hit_a || hit_b;
            end
        end
        tot_x = XW'(r_run) + ((r_cmd == CMD_START) ? XW'(1) : XW'(0));
        if (tot_x > XW'(VALUE_MAX)) begin
            tot_sat = VALUE_MAX;
        end else begin
            tot_sat = tot_x[POS_W-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ridx       = r_ridx;
        n_lim        = r_lim;
        n_aidx       = r_aidx;
        n_dv         = 1'b0;
        n_run        = r_run;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_value  = r_res_value;
        n_res_same   = r_res_same;
        tbl_we       = 1'b0;
        tbl_waddr    = panel_m1[IW-1:0];
        tbl_wdata    = DURATION_BITS'(r_duration);
        tbl_re       = 1'b0;
        tbl_raddr    = r_ridx[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_status = 1'b0;
                n_res_found  = '0;
                n_res_value  = '0;
                n_res_same   = 1'b0;
                n_ridx       = '0;
                n_aidx       = '0;
                n_run        = '0;
                n_lim        = CW'(cnt_pw);
                n_state      = ST_WALK;
                case (r_cmd)
                    CMD_SET_DUR: begin
                        tbl_we       = panel_ok;
                        n_res_status = !panel_ok;
                        n_state      = ST_OUT;
                    end
                    CMD_GET_DUR: begin
                        tbl_re    = panel_ok;
                        tbl_raddr = panel_m1[IW-1:0];
                        if (panel_ok) begin
                            n_state = ST_GETD;
                        end else begin
                            n_res_status = 1'b1;
                            n_state      = ST_OUT;
                        end
                    end
                    CMD_FIND: begin
                        if (r_pos_a == '0) begin
                            n_res_status = 1'b1;
                            n_state      = ST_OUT;
                        end
                    end
                    CMD_START: begin
                        if (panel_pw > cnt_pw) begin
                            n_res_status = 1'b1;
                            n_state      = ST_OUT;
                        end else if (panel_pw == '0) begin
                            n_lim = '0;
                        end else begin
                            n_lim = CW'(panel_m1);
                        end
                    end
                    CMD_LENGTH: begin
                    end
                    CMD_SAME: begin
                    end
                    default: begin
                        n_res_status = 1'b1;
                        n_state      = ST_OUT;
                    end
                endcase
            end
            ST_WALK: begin
                if (r_dv) begin
                    n_run  = run_sum;
                    n_aidx = r_aidx + 1'b1;
                end
                if (walk_stop) begin
                    n_state = ST_OUT;
                    if (r_cmd == CMD_FIND) begin
                        n_res_found = PANEL_W'(r_aidx) + 1'b1;
                    end else begin
                        n_res_same = hit_a && hit_b;
                    end
                end else if (walk_issue) begin
                    tbl_re = 1'b1;
                    n_ridx = r_ridx + 1'b1;
                    n_dv   = 1'b1;
                end else if (!r_dv) begin
                    // every entry in range has been summed
                    n_state = ST_OUT;
                    if (r_cmd == CMD_FIND) begin
                        n_res_status = 1'b1;
                    end else if (r_cmd == CMD_START || r_cmd == CMD_LENGTH) begin
                        n_res_value = tot_sat;
                    end
                end
            end
            ST_GETD: begin
                n_res_value = POS_W'(tbl_rdata);
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_panel_count <= '0;
            r_dv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            if (i_cfg_we) begin
                r_panel_count <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd      <= i_cmd;
            r_panel    <= i_panel;
            r_duration <= i_duration;
            r_pos_a    <= i_pos_a;
            r_pos_b    <= i_pos_b;
        end
        r_ridx       <= n_ridx;
        r_lim        <= n_lim;
        r_aidx       <= n_aidx;
        r_run        <= n_run;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_value  <= n_res_value;
        r_res_same   <= n_res_same;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_value  <= r_res_value;
            r_out_same   <= r_res_same;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_panel_found = r_out_found;
    assign o_value       = r_out_value;
    assign o_same_panel  = r_out_same;

    a_no_accept_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_clearing |-> !o_in_ready)
        else $error("command accepted during table clearing pass");

    a_walk_within_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_ridx <= r_lim))
        else $error("walk read index ran past its limit");

    a_error_has_no_panel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_panel_found == '0 && !o_same_panel))
        else $error("error result carries a found panel or same flag");

    a_accept_leads_to_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_EXEC))
        else $error("accepted command did not start execution");

    a_load_frees_engine : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == ST_IDLE))
        else $error("result load did not present output and return to idle");

endmodule

FILE: tb/timeline_checker.sv
// ---------------------------------------------------------------------------
// timeline_checker
// Watches the command and result channels of the panel duration timeline
// table. Keeps its own copy of the duration table and panel count, works out
// the answer for every accepted command and compares each accepted result
// against the oldest answer still due.
// ---------------------------------------------------------------------------
module timeline_checker
    import pdtt_pkg::*;
#(
    parameter int MAX_PANELS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PANEL_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [PANEL_W-1:0] i_panel,
    input  logic [DUR_W-1:0]   i_duration,
    input  logic [POS_W-1:0]   i_pos_a,
    input  logic [POS_W-1:0]   i_pos_b,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_status,
    input  logic [PANEL_W-1:0] i_panel_found,
    input  logic [POS_W-1:0]   i_value,
    input  logic               i_same_panel,
    input  logic               i_run_done,
    output int unsigned        o_results_seen,
    output int unsigned        o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_ERR  = 1'b1;
    localparam int   MAX_REPORTS = 40;

    typedef struct packed {
        logic               status;
        logic [PANEL_W-1:0] panel_found;
        logic [POS_W-1:0]   value;
        logic               same_panel;
    } t_answer;

    typedef struct {
        t_answer          ans;
        int unsigned      seq;
        logic [CMD_W-1:0] cmd;
    } t_due;

    logic [DUR_W-1:0]   durations [MAX_PANELS];
    logic [PANEL_W-1:0] panel_count;
    t_due               answers_due [$];
    int unsigned        n_taken;
    int unsigned        n_fail = 0;
    logic               done_seen = 1'b0;

    assign o_fail_count = n_fail;

    task automatic report_fail(input string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    task automatic check_field(input t_due d, input string field,
                               input logic [POS_W-1:0] got, input logic [POS_W-1:0] want);
        if (got !== want) begin
            report_fail($sformatf("result %0d (cmd %0d): %s is 0x%0h, expected 0x%0h",
                                  d.seq, d.cmd, field, got, want));
        end
    endtask

    function automatic int unsigned panels_in_use();
        return (panel_count > MAX_PANELS) ? MAX_PANELS : int'(panel_count);
    endfunction

    // running sum of the first n durations
    function automatic longint unsigned frames_through(input int unsigned n);
        longint unsigned s;
        int unsigned     k;
        s = 0;
        for (k = 0; k < n; k++) begin
            s += durations[k];
        end
        return s;
    endfunction

    function automatic logic [POS_W-1:0] clip_pos(input longint unsigned v);
        return (v > VALUE_MAX) ? VALUE_MAX : v[POS_W-1:0];
    endfunction

    function automatic t_answer answer_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic [PANEL_W-1:0] panel,
                                           input logic [DUR_W-1:0] dur,
                                           input logic [POS_W-1:0] pa,
                                           input logic [POS_W-1:0] pb);
        t_answer         a;
        int unsigned     n;
        int unsigned     k;
        longint unsigned run;
        a = '0;
        n = panels_in_use();
        run = 0;
        case (cmd)
            CMD_SET_DUR: begin
                if (panel == 0 || panel > n) a.status = STATUS_ERR;
                else durations[panel - 1] = dur;
            end
            CMD_GET_DUR: begin
                if (panel == 0 || panel > n) a.status = STATUS_ERR;
                else a.value = POS_W'(durations[panel - 1]);
            end
            CMD_FIND: begin
                if (pa == 0 || pa > frames_through(n)) begin
                    a.status = STATUS_ERR;
                end else begin
                    for (k = 0; k < n; k++) begin
                        run += durations[k];
                        if (run >= pa) begin
                            a.panel_found = PANEL_W'(k + 1);
                            break;
                        end
                    end
                end
            end
            CMD_START: begin
                if (panel > n) a.status = STATUS_ERR;
                else a.value = clip_pos(1 + frames_through((panel == 0) ? 0 : panel - 1));
            end
            CMD_LENGTH: begin
                a.value = clip_pos(frames_through(n));
            end
            CMD_SAME: begin
                // the first panel that reaches either position decides
                for (k = 0; k < n; k++) begin
                    run += durations[k];
                    if (run >= pa && run >= pb) begin
                        a.same_panel = 1'b1;
                        break;
                    end
                    if (run >= pa || run >= pb) break;
                end
            end
            default: begin
                a.status = STATUS_ERR;
            end
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_due d;
        if (!i_rst_n) begin
            foreach (durations[k]) durations[k] = '0;
            panel_count = '0;
            answers_due.delete();
            n_taken = 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                panel_count = i_cfg_wdata;
            end
            // compare before taking a new command: the result belongs to an older one
            if (i_out_valid && i_out_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (answers_due.size() == 0) begin
                    report_fail($sformatf(
                        "result with nothing due: status %0d panel %0d value 0x%0h same %0d",
                        i_status, i_panel_found, i_value, i_same_panel));
                end else begin
                    d = answers_due.pop_front();
                    check_field(d, "status", POS_W'(i_status), POS_W'(d.ans.status));
                    check_field(d, "panel_found", POS_W'(i_panel_found),
                                POS_W'(d.ans.panel_found));
                    check_field(d, "value", i_value, d.ans.value);
                    check_field(d, "same_panel", POS_W'(i_same_panel),
                                POS_W'(d.ans.same_panel));
                end
            end
            if (i_in_valid && i_in_ready) begin
                d.seq = n_taken;
                d.cmd = i_cmd;
                d.ans = answer_cmd(i_cmd, i_panel, i_duration, i_pos_a, i_pos_b);
                answers_due.push_back(d);
                n_taken++;
            end
            if (i_run_done && !done_seen) begin
                done_seen = 1'b1;
                foreach (answers_due[k]) begin
                    report_fail($sformatf("result %0d (cmd %0d) never arrived",
                                          answers_due[k].seq, answers_due[k].cmd));
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the panel duration timeline table: a directed
// pass over the corner cases, then random command mixes under several panel
// counts and idle/stall patterns, checked by timeline_checker.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pdtt_pkg::*;

    localparam int MAX_PANELS   = 256;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int N_PHASES     = 12;
    localparam int PHASE_ITEMS  = 110;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [PANEL_W-1:0] i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [CMD_W-1:0]   i_cmd       = '0;
    logic [PANEL_W-1:0] i_panel     = '0;
    logic [DUR_W-1:0]   i_duration  = '0;
    logic [POS_W-1:0]   i_pos_a     = '0;
    logic [POS_W-1:0]   i_pos_b     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_status;
    logic [PANEL_W-1:0] o_panel_found;
    logic [POS_W-1:0]   o_value;
    logic               o_same_panel;

    logic               run_done = 1'b0;
    int unsigned        results_seen;
    int unsigned        fail_count;

    // stimulus bookkeeping
    logic [PANEL_W-1:0] cur_count = '0;
    logic [DUR_W-1:0]   written_dur [MAX_PANELS];
    int unsigned        n_sent = 0;
    int unsigned        n_by_cmd [8];
    int unsigned        n_settings = 0;
    int unsigned        tx_idle_pct = 0;
    logic [PANEL_W-1:0] phase_count [N_PHASES] = '{9'd256, 9'd6, 9'd1, 9'd16, 9'd0, 9'd511,
                                                   9'd3, 9'd255, 9'd32, 9'd2, 9'd9, 9'd100};

    // receiver control, written with nonblocking assignments from the stimulus
    int unsigned        rx_stall_pct = 0;
    int unsigned        hold_token = 0;
    int unsigned        hold_seen = 0;
    int unsigned        hold_left = 0;
    int unsigned        quiet_cycles = 0;

    panel_duration_timeline_table #(
        .MAX_PANELS    (MAX_PANELS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_panel       (i_panel),
        .i_duration    (i_duration),
        .i_pos_a       (i_pos_a),
        .i_pos_b       (i_pos_b),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_panel_found (o_panel_found),
        .o_value       (o_value),
        .o_same_panel  (o_same_panel)
    );

    timeline_checker #(
        .MAX_PANELS     (MAX_PANELS)
    ) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_panel        (i_panel),
        .i_duration     (i_duration),
        .i_pos_a        (i_pos_a),
        .i_pos_b        (i_pos_b),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_panel_found  (o_panel_found),
        .i_value        (o_value),
        .i_same_panel   (o_same_panel),
        .i_run_done     (run_done),
        .o_results_seen (results_seen),
        .o_fail_count   (fail_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off whenever the token moves
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("panel_duration_timeline_table: mismatch");
            $finish;
        end
    end

    function automatic int unsigned used_panels();
        return (cur_count > MAX_PANELS) ? MAX_PANELS : int'(cur_count);
    endfunction

    function automatic int unsigned timeline_total();
        int unsigned s;
        int unsigned k;
        s = 0;
        for (k = 0; k < used_panels(); k++) begin
            s += written_dur[k];
        end
        return s;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input int unsigned total);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return POS_W'($urandom);
        if (r == 1) return POS_W'($urandom_range(3));
        return POS_W'($urandom_range(total + 1));
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [PANEL_W-1:0] pn,
                            input logic [DUR_W-1:0] d, input logic [POS_W-1:0] pa,
                            input logic [POS_W-1:0] pb);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_panel    <= pn;
        i_duration <= d;
        i_pos_a    <= pa;
        i_pos_b    <= pb;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        n_by_cmd[c]++;
        if (c == CMD_SET_DUR && pn != 0 && pn <= used_panels()) written_dur[pn - 1] = d;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (results_seen < n_sent) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [PANEL_W-1:0] n);
        wait_drain();
        // the block steps back to idle right after its last result
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_count = n;
        n_settings++;
    endtask

    task automatic send_random();
        int unsigned        pick;
        int unsigned        r;
        int unsigned        total;
        logic [CMD_W-1:0]   c;
        logic [PANEL_W-1:0] pn;
        logic [DUR_W-1:0]   d;
        logic [POS_W-1:0]   pa;
        logic [POS_W-1:0]   pb;
        total = timeline_total();
        pick = $urandom_range(99);
        if (pick < 30) c = CMD_SET_DUR;
        else if (pick < 42) c = CMD_GET_DUR;
        else if (pick < 60) c = CMD_FIND;
        else if (pick < 72) c = CMD_START;
        else if (pick < 78) c = CMD_LENGTH;
        else if (pick < 96) c = CMD_SAME;
        else c = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
        pn = ($urandom_range(9) == 0) ? PANEL_W'($urandom)
                                      : PANEL_W'($urandom_range(used_panels() + 1));
        r = $urandom_range(19);
        if (r == 0) d = DUR_W'($urandom);
        else if (r < 3) d = '0;
        else d = DUR_W'($urandom_range(20, 1));
        pa = pick_pos(total);
        // nearby pairs land in the same or adjacent panels more often
        pb = $urandom_range(1) ? pick_pos(total) : pa + POS_W'($urandom_range(8));
        send_cmd(c, pn, d, pa, pb);
    endtask

    initial begin
        int p;
        int k;
        foreach (written_dur[i]) written_dur[i] = '0;
        foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty timeline: the count is zero after reset
        send_cmd(CMD_LENGTH, 0, 0, 0, 0);
        send_cmd(CMD_START, 0, 0, 0, 0);
        send_cmd(CMD_GET_DUR, 1, 0, 0, 0);
        send_cmd(CMD_FIND, 0, 0, 1, 0);
        send_cmd(CMD_SAME, 0, 0, 0, 0);
        send_cmd(CMD_SPARE_7, 9'h1FF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);

        // four panels: 5, 0, 65535, 3 frames
        write_count(9'd4);
        send_cmd(CMD_SET_DUR, 1, 5, 0, 0);
        send_cmd(CMD_SET_DUR, 2, 0, 0, 0);
        send_cmd(CMD_SET_DUR, 3, 16'hFFFF, 0, 0);
        send_cmd(CMD_SET_DUR, 4, 3, 0, 0);
        send_cmd(CMD_SET_DUR, 0, 7, 0, 0);
        send_cmd(CMD_SET_DUR, 5, 9, 0, 0);
        send_cmd(CMD_GET_DUR, 9'h1FF, 0, 0, 0);
        send_cmd(CMD_GET_DUR, 3, 0, 0, 0);
        send_cmd(CMD_FIND, 0, 0, 5, 0);
        send_cmd(CMD_FIND, 0, 0, 6, 0);
        send_cmd(CMD_FIND, 0, 0, 65543, 0);
        send_cmd(CMD_FIND, 0, 0, 65544, 0);
        send_cmd(CMD_FIND, 0, 0, 0, 0);
        send_cmd(CMD_START, 0, 0, 0, 0);
        send_cmd(CMD_START, 3, 0, 0, 0);
        send_cmd(CMD_START, 5, 0, 0, 0);
        send_cmd(CMD_LENGTH, 0, 0, 0, 0);
        send_cmd(CMD_SAME, 0, 0, 2, 5);
        send_cmd(CMD_SAME, 0, 0, 5, 6);
        send_cmd(CMD_SAME, 0, 0, 0, 3);
        send_cmd(CMD_SAME, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
        send_cmd(CMD_SPARE_6, 0, 0, 0, 0);

        for (p = 0; p < N_PHASES; p++) begin
            write_count(phase_count[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 51; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 51; end
                default: begin tx_idle_pct = 30; rx_stall_pct <= 30; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // receiver holds off while commands keep coming
                if (p == 0 && k == 10) hold_token <= hold_token + 1;
                // sender pauses until the table has answered everything
                if (p == 5 && k == 55) wait_drain();
                send_random();
            end
        end

        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("covered %0d transactions over %0d panel-count settings (0 to 511)",
                 n_sent, n_settings);
        $display("set %0d, get %0d, find %0d, start %0d, length %0d, same %0d, unused %0d",
                 n_by_cmd[CMD_SET_DUR], n_by_cmd[CMD_GET_DUR], n_by_cmd[CMD_FIND],
                 n_by_cmd[CMD_START], n_by_cmd[CMD_LENGTH], n_by_cmd[CMD_SAME],
                 n_by_cmd[CMD_SPARE_6] + n_by_cmd[CMD_SPARE_7]);
        if (fail_count == 0) begin
            $display("panel_duration_timeline_table: match");
        end else begin
            $display("panel_duration_timeline_table: mismatch");
        end
        $finish;
    end

endmodule
